// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the checkers of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: design/fods_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fods_pkg
// Constants, types and register codes of the fourth-order diffusion stencil.
// ----------------------------------------------------------------------------
package fods_pkg;

    localparam int MAX_ROW_LENGTH = 1024;
    localparam int SAMPLE_BITS    = 16;
    localparam int ALPHA_BITS     = 16;
    localparam int LINE_ROWS      = 4;
    localparam int WIN            = 5;
    localparam int STENCIL_REACH  = 2;

    localparam int ADDR_BITS  = $clog2(MAX_ROW_LENGTH);
    localparam int LEN_BITS   = ADDR_BITS + 1;
    localparam int WIDTH_BITS  = 10;
    localparam int HEIGHT_BITS = 16;
    localparam int HALO_BITS   = 4;
    localparam int PLANE_BITS  = 16;
    localparam int ROW_BITS    = HEIGHT_BITS + 1;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Stencil sum needs 7 bits of growth (coefficient magnitudes add up to 64).
    localparam int ACC_BITS    = SAMPLE_BITS + 7;
    localparam int PROD_BITS   = ACC_BITS + ALPHA_BITS + 1;
    localparam int TOTAL_BITS  = PROD_BITS + 1;
    localparam int SCALED_BITS = TOTAL_BITS - ALPHA_BITS;

    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    localparam logic [HALO_BITS-1:0]   HALO_MIN = HALO_BITS'(2);
    localparam logic [HALO_BITS-1:0]   HALO_MAX = HALO_BITS'(8);

    localparam logic [ALPHA_BITS-1:0]  RESET_WEIGHT_ALPHA    = '0;
    localparam logic [WIDTH_BITS-1:0]  RESET_INTERIOR_WIDTH  = WIDTH_BITS'(64);
    localparam logic [HEIGHT_BITS-1:0] RESET_INTERIOR_HEIGHT = HEIGHT_BITS'(64);
    localparam logic [HALO_BITS-1:0]   RESET_HALO_WIDTH      = HALO_BITS'(2);
    localparam logic [PLANE_BITS-1:0]  RESET_PLANE_COUNT     = PLANE_BITS'(1);

    localparam logic signed [TOTAL_BITS-1:0]  ROUND_HALF = TOTAL_BITS'(1) << (ALPHA_BITS - 1);
    localparam logic signed [SCALED_BITS-1:0] SCALED_MAX =
        SCALED_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SCALED_BITS-1:0] SCALED_MIN =
        SCALED_BITS'(-(1 << (SAMPLE_BITS - 1)));

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WEIGHT_ALPHA    = 3'd0,
        CFG_INTERIOR_WIDTH  = 3'd1,
        CFG_INTERIOR_HEIGHT = 3'd2,
        CFG_HALO_WIDTH      = 3'd3,
        CFG_PLANE_COUNT     = 3'd4
    } t_cfg_index;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [WIN-1:0] t_taps;
    typedef t_taps [WIN-1:0] t_window;

    typedef struct packed {
        logic last_plane;
        logic last_volume;
    } t_tag;

    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic [ADDR_BITS-1:0] wr_addr;
    } t_line_ctrl;

    typedef struct packed {
        t_sample value;
        logic    saturated;
        logic    last_plane;
        logic    last_volume;
    } t_result;

    typedef struct packed {
        logic [LEN_BITS-1:0]   row_len;
        logic [LEN_BITS-1:0]   x_lo;
        logic [LEN_BITS-1:0]   x_hi;
        logic [LEN_BITS-1:0]   x_last;
        logic [ROW_BITS-1:0]   rows;
        logic [ROW_BITS-1:0]   y_lo;
        logic [ROW_BITS-1:0]   y_hi;
        logic [ROW_BITS-1:0]   y_last;
        logic [PLANE_BITS-1:0] planes;
    } t_geom;

endpackage

// File: design/fods_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fods_in_if / fods_out_if
// Valid/ready word channels for samples in and diffused results out.
// ----------------------------------------------------------------------------
interface fods_in_if;
    logic              valid;
    logic              ready;
    fods_pkg::t_sample sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

interface fods_out_if;
    logic              valid;
    logic              ready;
    fods_pkg::t_sample result_value;
    logic              saturated;
    logic              last_of_plane;
    logic              last_of_volume;

    modport source (output valid, output result_value, output saturated,
                     output last_of_plane, output last_of_volume, input ready);
    modport sink (input valid, input result_value, input saturated,
                  input last_of_plane, input last_of_volume, output ready);
endinterface

// File: design/fods_line_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fods_line_cell
// One row of the window: a row buffer in block memory and five window taps.
// ----------------------------------------------------------------------------
module fods_line_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fods_pkg::t_line_ctrl i_ctrl,
    input  fods_pkg::t_sample    i_below,
    input  logic                 i_shift,
    output fods_pkg::t_sample    o_column,
    output fods_pkg::t_taps      o_taps
);
    import fods_pkg::*;

    t_sample r_mem [MAX_ROW_LENGTH];
    t_sample r_rdata;
    t_taps   r_taps;

    // The write of one column and the read of the next never share an address.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_addr] <= i_below;
        end
        if (i_ctrl.rd_en) begin
            r_rdata <= r_mem[i_ctrl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= '0;
        end else if (i_shift) begin
            r_taps <= {r_rdata, r_taps[WIN-1:1]};
        end
    end

    assign o_column = r_rdata;
    assign o_taps   = r_taps;

endmodule

// File: design/fods_stencil_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fods_stencil_arith
// Thirteen-point weighted sum, scaling by the weight, rounding and clipping.
// ----------------------------------------------------------------------------
module fods_stencil_arith (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  fods_pkg::t_tag                  i_tag,
    input  fods_pkg::t_window               i_window,
    input  logic [fods_pkg::ALPHA_BITS-1:0] i_alpha,
    output logic                            o_valid,
    output fods_pkg::t_result               o_result
);
    import fods_pkg::*;

    logic signed [ACC_BITS-1:0]    n_ctr;
    logic signed [ACC_BITS-1:0]    n_direct;
    logic signed [ACC_BITS-1:0]    n_diag;
    logic signed [ACC_BITS-1:0]    n_far;
    logic signed [ACC_BITS-1:0]    n_acc;
    logic signed [PROD_BITS-1:0]   n_prod;
    logic signed [TOTAL_BITS-1:0]  n_total;
    logic signed [SCALED_BITS-1:0] n_scaled;

    logic                          r_acc_valid;
    t_tag                          r_acc_tag;
    logic signed [ACC_BITS-1:0]    r_acc;
    t_sample                       r_acc_ctr;
    logic                          r_prod_valid;
    t_tag                          r_prod_tag;
    logic signed [PROD_BITS-1:0]   r_prod;
    t_sample                       r_prod_ctr;

    function automatic logic signed [ACC_BITS-1:0] widen(input t_sample v);
        return ACC_BITS'($signed(v));
    endfunction

    always_comb begin
        n_ctr    = widen(i_window[2][2]);
        n_direct = widen(i_window[2][1]) + widen(i_window[2][3])
                 + widen(i_window[1][2]) + widen(i_window[3][2]);
        n_diag   = widen(i_window[1][1]) + widen(i_window[1][3])
                 + widen(i_window[3][1]) + widen(i_window[3][3]);
        n_far    = widen(i_window[2][0]) + widen(i_window[2][4])
                 + widen(i_window[0][2]) + widen(i_window[4][2]);
        // -20c + 8*direct - 2*diag - far, built from shifts.
        n_acc    = (n_direct <<< 3) - (n_ctr <<< 4) - (n_ctr <<< 2)
                 - (n_diag <<< 1) - n_far;
    end

    assign n_prod = r_acc * $signed({1'b0, i_alpha});

    always_comb begin
        n_total  = (TOTAL_BITS'($signed(r_prod_ctr)) <<< ALPHA_BITS)
                 + TOTAL_BITS'(r_prod) + ROUND_HALF;
        // Arithmetic right shift gives the floor of the quotient.
        n_scaled = n_total[TOTAL_BITS-1:ALPHA_BITS];
        o_result.last_plane  = r_prod_tag.last_plane;
        o_result.last_volume = r_prod_tag.last_volume;
        if (n_scaled > SCALED_MAX) begin
            o_result.value     = SCALED_MAX[SAMPLE_BITS-1:0];
            o_result.saturated = 1'b1;
        end else if (n_scaled < SCALED_MIN) begin
            o_result.value     = SCALED_MIN[SAMPLE_BITS-1:0];
            o_result.saturated = 1'b1;
        end else begin
            o_result.value     = n_scaled[SAMPLE_BITS-1:0];
            o_result.saturated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_valid  <= 1'b0;
            r_prod_valid <= 1'b0;
        end else begin
            r_acc_valid  <= i_valid;
            r_prod_valid <= r_acc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_tag  <= i_tag;
        r_acc      <= n_acc;
        r_acc_ctr  <= i_window[2][2];
        r_prod_tag <= r_acc_tag;
        r_prod     <= n_prod;
        r_prod_ctr <= r_acc_ctr;
    end

    assign o_valid = r_prod_valid;

endmodule

// File: design/fods_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fods_out_fifo
// Small result queue that decouples the stencil pipeline from the sink.
// ----------------------------------------------------------------------------
module fods_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fods_pkg::t_result i_push_data,
    input  logic              i_pop,
    output logic              o_valid,
    output fods_pkg::t_result o_data
);
    import fods_pkg::*;

    t_result                  r_entries [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;
    logic [FIFO_CNT_BITS-1:0] n_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_push_data;
        end
    end

    assign n_count = r_count + FIFO_CNT_BITS'(i_push) - FIFO_CNT_BITS'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_BITS'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_entries[r_rd_ptr];

endmodule

// File: design/fourth_order_diffusion_stencil.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fourth_order_diffusion_stencil
// Streaming thirteen-point fourth-order diffusion step over a 3D field.
// ----------------------------------------------------------------------------
// Samples enter one word per cycle in raster order with their halo while input
// is not held off, and every interior point leaves as one diffused word after
// the sample that completes its 5x5 neighborhood; halo points give no word.
// The rate of one word per cycle is set by the chain of four row-buffer cells,
// each a single block memory read and written once per word, followed by a
// weighted-sum stage and a multiply stage, with rounding and clipping done
// combinationally into an eight-word output queue that lets input continue
// while results wait. Input stalls only when the queue and pipeline hold eight
// pending results, and after reset and each register write while the row
// geometry is recomputed. Row buffers are not cleared after reset.
// ----------------------------------------------------------------------------
module fourth_order_diffusion_stencil (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fods_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [fods_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    fods_in_if.sink                             i_in,
    fods_out_if.source                          o_out
);
    import fods_pkg::*;

    // Configuration registers.
    logic [ALPHA_BITS-1:0]  r_weight_alpha;
    logic [WIDTH_BITS-1:0]  r_interior_width;
    logic [HEIGHT_BITS-1:0] r_interior_height;
    logic [HALO_BITS-1:0]   r_halo_width;
    logic [PLANE_BITS-1:0]  r_plane_count;
    logic [1:0]             r_cfg_hold;

    // Derived geometry.
    logic [HALO_BITS-1:0]   n_halo;
    logic [LEN_BITS-1:0]    n_halo2;
    logic [LEN_BITS-1:0]    n_nx_cap;
    logic [LEN_BITS-1:0]    n_nx;
    t_geom                  n_geom;
    t_geom                  r_geom;

    // Scan counters.
    logic [ADDR_BITS-1:0]   r_col;
    logic [ROW_BITS-1:0]    r_row;
    logic [PLANE_BITS-1:0]  r_plane;
    logic [ADDR_BITS-1:0]   n_col;
    logic [ROW_BITS-1:0]    n_row;
    logic [PLANE_BITS-1:0]  n_plane;

    logic                   w_in_ready;
    logic                   w_accept;
    logic [LEN_BITS-1:0]    w_x;
    logic                   w_interior;
    logic                   w_row_end;
    logic                   w_plane_end;
    logic                   w_volume_end;
    t_tag                   w_tag;

    // Pipeline stage that follows the memory read.
    logic                   r_s1_valid;
    logic                   r_s1_interior;
    logic [ADDR_BITS-1:0]   r_s1_col;
    t_sample                r_s1_sample;
    t_tag                   r_s1_tag;
    logic                   r_s2_valid;
    t_tag                   r_s2_tag;

    t_line_ctrl             w_line_ctrl;
    t_sample                w_col [LINE_ROWS+1];
    t_taps                  w_cell_taps [LINE_ROWS];
    t_taps                  r_bottom_taps;
    t_window                w_window;

    logic                   w_push;
    t_result                w_push_data;
    logic                   w_pop;
    logic                   w_out_valid;
    t_result                w_out_data;
    logic [FIFO_CNT_BITS-1:0] r_reserved;
    logic [FIFO_CNT_BITS-1:0] n_reserved;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_alpha    <= RESET_WEIGHT_ALPHA;
            r_interior_width  <= RESET_INTERIOR_WIDTH;
            r_interior_height <= RESET_INTERIOR_HEIGHT;
            r_halo_width      <= RESET_HALO_WIDTH;
            r_plane_count     <= RESET_PLANE_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WEIGHT_ALPHA:    r_weight_alpha    <= i_cfg_data[ALPHA_BITS-1:0];
                CFG_INTERIOR_WIDTH:  r_interior_width  <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_INTERIOR_HEIGHT: r_interior_height <= i_cfg_data[HEIGHT_BITS-1:0];
                CFG_HALO_WIDTH:      r_halo_width      <= i_cfg_data[HALO_BITS-1:0];
                CFG_PLANE_COUNT:     r_plane_count     <= i_cfg_data[PLANE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_hold <= 2'b11;
        end else begin
            r_cfg_hold <= {r_cfg_hold[0], i_cfg_we};
        end
    end

    always_comb begin
        if (r_halo_width < HALO_MIN) begin
            n_halo = HALO_MIN;
        end else if (r_halo_width > HALO_MAX) begin
            n_halo = HALO_MAX;
        end else begin
            n_halo = r_halo_width;
        end
        n_halo2  = LEN_BITS'(n_halo) << 1;
        n_nx_cap = LEN_BITS'(MAX_ROW_LENGTH) - n_halo2;
        n_nx     = (LEN_BITS'(r_interior_width) < n_nx_cap) ?
                   LEN_BITS'(r_interior_width) : n_nx_cap;

        n_geom.row_len = n_nx + n_halo2;
        n_geom.x_lo    = LEN_BITS'(n_halo) + LEN_BITS'(STENCIL_REACH);
        n_geom.x_hi    = n_nx + LEN_BITS'(n_halo) + LEN_BITS'(STENCIL_REACH);
        n_geom.x_last  = n_nx + LEN_BITS'(n_halo) + LEN_BITS'(STENCIL_REACH - 1);
        n_geom.rows    = ROW_BITS'(r_interior_height) + ROW_BITS'(n_halo2);
        n_geom.y_lo    = ROW_BITS'(n_halo) + ROW_BITS'(STENCIL_REACH);
        n_geom.y_hi    = ROW_BITS'(r_interior_height) + ROW_BITS'(n_halo)
                       + ROW_BITS'(STENCIL_REACH);
        n_geom.y_last  = ROW_BITS'(r_interior_height) + ROW_BITS'(n_halo)
                       + ROW_BITS'(STENCIL_REACH - 1);
        n_geom.planes  = (r_plane_count == '0) ? PLANE_BITS'(1) : r_plane_count;
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    // A word is taken when a result slot can be reserved for it and the geometry is not being recomputed.
    assign w_in_ready = (r_cfg_hold == 2'b00) && (r_reserved < FIFO_CNT_BITS'(FIFO_DEPTH));
    assign w_accept   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    assign w_x = LEN_BITS'(r_col);

    always_comb begin
        // The word at (x, y) completes the point two columns and two rows back.
        w_interior = (w_x >= r_geom.x_lo) && (w_x < r_geom.x_hi)
                  && (r_row >= r_geom.y_lo) && (r_row < r_geom.y_hi);
        w_row_end    = (w_x + LEN_BITS'(1)) >= r_geom.row_len;
        w_plane_end  = ({1'b0, r_row} + (ROW_BITS + 1)'(1)) >= {1'b0, r_geom.rows};
        w_volume_end = ({1'b0, r_plane} + (PLANE_BITS + 1)'(1)) >= {1'b0, r_geom.planes};
        w_tag.last_plane  = (w_x == r_geom.x_last) && (r_row == r_geom.y_last);
        w_tag.last_volume = w_tag.last_plane && w_volume_end;

        n_col   = r_col + ADDR_BITS'(1);
        n_row   = r_row;
        n_plane = r_plane;
        if (w_row_end) begin
            n_col = '0;
            if (w_plane_end) begin
                n_row   = '0;
                n_plane = w_volume_end ? '0 : (r_plane + PLANE_BITS'(1));
            end else begin
                n_row = r_row + ROW_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_plane <= '0;
        end else if (w_accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_plane <= n_plane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid && r_s1_interior;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_interior <= w_interior;
        r_s1_col      <= r_col;
        r_s1_sample   <= i_in.sample_value;
        r_s1_tag      <= w_tag;
        r_s2_tag      <= r_s1_tag;
    end

    // Each buffer is read when the word arrives and rewritten in the next cycle.
    always_comb begin
        w_line_ctrl.rd_en   = w_accept;
        w_line_ctrl.rd_addr = r_col;
        w_line_ctrl.wr_en   = r_s1_valid;
        w_line_ctrl.wr_addr = r_s1_col;
    end

    assign w_col[LINE_ROWS] = r_s1_sample;

    for (genvar g_row = 0; g_row < LINE_ROWS; g_row++) begin : g_cells
        fods_line_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_line_ctrl),
            .i_below  (w_col[g_row+1]),
            .i_shift  (r_s1_valid),
            .o_column (w_col[g_row]),
            .o_taps   (w_cell_taps[g_row])
        );
        assign w_window[g_row] = w_cell_taps[g_row];
    end

    // The newest row of the window comes straight from the input word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bottom_taps <= '0;
        end else if (r_s1_valid) begin
            r_bottom_taps <= {r_s1_sample, r_bottom_taps[WIN-1:1]};
        end
    end

    assign w_window[LINE_ROWS] = r_bottom_taps;

    fods_stencil_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s2_valid),
        .i_tag    (r_s2_tag),
        .i_window (w_window),
        .i_alpha  (r_weight_alpha),
        .o_valid  (w_push),
        .o_result (w_push_data)
    );

    assign w_pop = w_out_valid && o_out.ready;

    fods_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_valid     (w_out_valid),
        .o_data      (w_out_data)
    );

    assign n_reserved = r_reserved + FIFO_CNT_BITS'(w_accept && w_interior)
                      - FIFO_CNT_BITS'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved <= '0;
        end else begin
            r_reserved <= n_reserved;
        end
    end

    assign o_out.valid          = w_out_valid;
    assign o_out.result_value   = w_out_data.value;
    assign o_out.saturated      = w_out_data.saturated;
    assign o_out.last_of_plane  = w_out_data.last_plane;
    assign o_out.last_of_volume = w_out_data.last_volume;

endmodule

// File: design/fods_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fods_checker
// Port-level checks of the diffusion stencil, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fods_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_we,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input fods_pkg::t_sample i_out_value,
    input logic              i_out_sat,
    input logic              i_out_lp,
    input logic              i_out_lv
);
    import fods_pkg::*;

    // Reset empties the result queue.
    `ASSERT_NEXT_ALWAYS(a_reset_empties_queue, i_clk, !i_rst_n, !i_out_valid)

    // Input waits while the geometry follows a register write.
    `ASSERT_NEXT(a_cfg_write_holds_input, i_clk, i_rst_n, i_cfg_we, !i_in_ready)

    // The end of the volume is always the end of a plane.
    `ASSERT_IMPL(a_volume_end_is_plane_end, i_clk, i_rst_n, i_out_valid && i_out_lv, i_out_lp)

    `ASSERT_NEXT(a_stalled_word_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_value) && $stable(i_out_sat) && $stable(i_out_lp) && $stable(i_out_lv))

endmodule

bind fourth_order_diffusion_stencil fods_checker u_fods_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.result_value),
    .i_out_sat   (o_out.saturated),
    .i_out_lp    (o_out.last_of_plane),
    .i_out_lv    (o_out.last_of_volume)
);
